@@ rtl/csvfp_pkg.sv @@
// ----------------------------------------------------------------------------
// csvfp_pkg
// Shared types and constants for the csv field parser.
// ----------------------------------------------------------------------------
package csvfp_pkg;

	localparam int FIELD_INDEX_MAX = 255;
	localparam logic [7:0] INDEX_CAP =
		(FIELD_INDEX_MAX > 255) ? 8'd255 : 8'(FIELD_INDEX_MAX);

	localparam logic [7:0] NEWLINE_BYTE   = 8'h0A;
	localparam logic [7:0] DELIMITER_RST  = 8'd44;
	localparam logic [7:0] QUOTE_CHAR_RST = 8'd34;

	typedef enum logic [0:0] {
		REG_DELIMITER  = 1'b0,
		REG_QUOTE_CHAR = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_START  = 2'd0,
		MODE_QUOTED = 2'd1,
		MODE_PLAIN  = 2'd2,
		MODE_AFTERQ = 2'd3
	} parse_mode_t;

	typedef struct packed {
		parse_mode_t parse_mode;
		logic        discarding;
		logic [7:0]  field_counter;
	} parse_state_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic       has_char;
		logic [7:0] char_out;
		logic       field_done;
		logic       line_done;
		logic       parse_error;
		logic [7:0] field_index;
	} out_item_t;

endpackage

@@ rtl/csvfp_step.sv @@
// ----------------------------------------------------------------------------
// csvfp_step
// Next-state and result logic for one byte of the field parser.
// ----------------------------------------------------------------------------
module csvfp_step (
	input  csvfp_pkg::parse_state_t st,
	input  csvfp_pkg::in_item_t     item,
	input  logic [7:0]              delimiter,
	input  logic [7:0]              quote_char,
	output csvfp_pkg::parse_state_t st_nxt,
	output logic                    res_valid,
	output csvfp_pkg::out_item_t    res
);
	import csvfp_pkg::*;

	logic       is_nl, is_q, is_d, last;
	logic       hc, fd, pe, any, bump;
	logic [7:0] cnt_bumped;
	parse_mode_t mode_nxt;

	assign is_nl = (item.data_byte == NEWLINE_BYTE);
	assign is_q  = (item.data_byte == quote_char);
	// quote wins when both registers hold the same byte
	assign is_d  = !is_q && (item.data_byte == delimiter);
	assign last  = item.last_byte;

	always_comb begin
		hc       = 1'b0;
		fd       = 1'b0;
		pe       = 1'b0;
		any      = 1'b0;
		bump     = 1'b0;
		mode_nxt = st.parse_mode;
		unique case (st.parse_mode)
			MODE_START: begin
				if (is_q) begin
					mode_nxt = MODE_QUOTED;
				end else if (is_d) begin
					fd   = 1'b1;
					any  = 1'b1;
					bump = 1'b1;
				end else begin
					hc       = 1'b1;
					any      = 1'b1;
					mode_nxt = MODE_PLAIN;
				end
			end
			MODE_QUOTED: begin
				if (is_q) begin
					mode_nxt = MODE_AFTERQ;
				end else begin
					hc  = 1'b1;
					any = 1'b1;
				end
			end
			MODE_PLAIN: begin
				if (is_d) begin
					fd       = 1'b1;
					any      = 1'b1;
					bump     = 1'b1;
					mode_nxt = MODE_START;
				end else begin
					hc  = 1'b1;
					any = 1'b1;
				end
			end
			MODE_AFTERQ: begin
				if (is_q) begin
					hc       = 1'b1;
					any      = 1'b1;
					mode_nxt = MODE_QUOTED;
				end else if (is_d) begin
					fd       = 1'b1;
					any      = 1'b1;
					bump     = 1'b1;
					mode_nxt = MODE_START;
				end else begin
					pe  = 1'b1;
					any = 1'b1;
				end
			end
			default: begin
				mode_nxt = MODE_START;
			end
		endcase
	end

	assign cnt_bumped = (bump && (st.field_counter < INDEX_CAP)) ?
		st.field_counter + 8'd1 : st.field_counter;

	always_comb begin
		res_valid          = 1'b0;
		res                = '0;
		res.field_index    = st.field_counter;
		st_nxt             = st;
		if (st.discarding) begin
			if (is_nl || last) begin
				res_valid     = 1'b1;
				res.line_done = 1'b1;
				st_nxt        = '{MODE_START, 1'b0, 8'd0};
			end
		end else if (is_nl) begin
			res_valid      = 1'b1;
			res.field_done = 1'b1;
			res.line_done  = 1'b1;
			st_nxt         = '{MODE_START, 1'b0, 8'd0};
		end else if (pe) begin
			res_valid       = 1'b1;
			res.parse_error = 1'b1;
			res.line_done   = last;
			st_nxt          = last ? '{MODE_START, 1'b0, 8'd0} :
				'{st.parse_mode, 1'b1, st.field_counter};
		end else if (last) begin
			// last byte closes the final field, maybe an empty one
			res_valid       = 1'b1;
			res.has_char    = hc;
			res.char_out    = hc ? item.data_byte : 8'd0;
			res.field_done  = 1'b1;
			res.line_done   = 1'b1;
			res.field_index = cnt_bumped;
			st_nxt          = '{MODE_START, 1'b0, 8'd0};
		end else begin
			res_valid      = any;
			res.has_char   = hc;
			res.char_out   = hc ? item.data_byte : 8'd0;
			res.field_done = fd;
			st_nxt         = '{mode_nxt, 1'b0, cnt_bumped};
		end
	end

endmodule

@@ rtl/csv_field_parser_core.sv @@
// ----------------------------------------------------------------------------
// csv_field_parser_core
// Byte-serial csv field tokenizer with configurable delimiter and quote.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | word
//  in      | in  | in_valid/in_stall  | in_item_t  (data_byte, last_byte)
//  out     | out | out_valid/out_stall| out_item_t (char, marks, field_index)
//  cfg     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  one byte per cycle while in_stall is low; path: input register, then parser step
//  into the result register
//  reset: delimiter ',', quote '"', parser at field start, field index zero
//  a byte that gives no result leaves the input register even if out is stalled
//  in_stall rises only when the input register holds a byte whose result
//  cannot yet enter the full, stalled result register
// ----------------------------------------------------------------------------
module csv_field_parser_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  csvfp_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output csvfp_pkg::out_item_t out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  csvfp_pkg::cfg_reg_t  cfg_index,
	input  logic [7:0]           cfg_data
);
	import csvfp_pkg::*;

	logic         valid_s1;
	in_item_t     item_s1;
	parse_state_t st_q;
	parse_state_t st_nxt;
	logic         res_valid;
	out_item_t    res;
	logic         advance;
	logic         out_valid_q;
	out_item_t    out_data_q;
	logic [7:0]   delimiter_q;
	logic [7:0]   quote_char_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delimiter_q  <= DELIMITER_RST;
			quote_char_q <= QUOTE_CHAR_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DELIMITER:  delimiter_q  <= cfg_data;
				REG_QUOTE_CHAR: quote_char_q <= cfg_data;
				default: ;
			endcase
		end
	end

	csvfp_step u_step (
		.st         (st_q),
		.item       (item_s1),
		.delimiter  (delimiter_q),
		.quote_char (quote_char_q),
		.st_nxt     (st_nxt),
		.res_valid  (res_valid),
		.res        (res)
	);

	// byte moves on when it has no result or the result slot is free
	assign advance  = valid_s1 && (!res_valid || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{MODE_START, 1'b0, 8'd0};
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTH
	a_err_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.parse_error &&
			(out_data.has_char || out_data.field_done)))
		else $error("parse error word carries a character or field end");

	a_line_resets: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_valid && res.line_done |=>
			st_q.field_counter == 8'd0 && !st_q.discarding &&
			st_q.parse_mode == MODE_START)
		else $error("parser state not cleared after line end");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !(advance && res_valid))
		else $error("result register overwritten while stalled");

	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.field_counter <= INDEX_CAP)
		else $error("field counter above cap");
`endif

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the csv field parser: a directed table of bytes,
// then phases of random lines under different delimiter and quote settings,
// with random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

	import csvfp_pkg::*;

	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 190;
	localparam int DRAIN_CYCLES   = 4;

	typedef struct {
		in_item_t  item;
		int        reps;
		bit        typed;
		bit        silent;
		out_item_t want;
	} stim_row_t;

	typedef struct {
		logic [7:0] sep;
		logic [7:0] quo;
	} reg_pair_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	in_item_t   in_data   = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_item_t  out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	cfg_reg_t   cfg_index = REG_DELIMITER;
	logic [7:0] cfg_data  = '0;

	// parser copy used for prediction
	parse_mode_t cur_mode = MODE_START;
	bit          dropping = 1'b0;
	logic [7:0]  field_no = '0;
	logic [7:0]  sep_byte = DELIMITER_RST;
	logic [7:0]  quo_byte = QUOTE_CHAR_RST;

	out_item_t pending_results[$];
	out_item_t oldest;
	int        mismatch_count = 0;
	int        idle_cycles    = 0;
	int        sent_in_phase  = 0;
	int        gap_pct        = 0;
	int        stall_pct      = 0;
	bit        calm           = 1'b0;
	bit        hold_req       = 1'b0;

	always #5 clk = ~clk;

	csv_field_parser_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	function automatic in_item_t mk(logic [7:0] b, bit last);
		in_item_t it;
		it.data_byte = b;
		it.last_byte = last;
		return it;
	endfunction

	function automatic out_item_t res(bit hc, logic [7:0] ch, bit fd, bit ld, bit pe,
			logic [7:0] idx);
		out_item_t r;
		r.has_char    = hc;
		r.char_out    = ch;
		r.field_done  = fd;
		r.line_done   = ld;
		r.parse_error = pe;
		r.field_index = idx;
		return r;
	endfunction

	function automatic stim_row_t row(logic [7:0] b, bit last, int reps, bit typed,
			bit silent, out_item_t want);
		stim_row_t s;
		s.item   = mk(b, last);
		s.reps   = reps;
		s.typed  = typed;
		s.silent = silent;
		s.want   = want;
		return s;
	endfunction

	function automatic void line_reset();
		cur_mode = MODE_START;
		dropping = 1'b0;
		field_no = '0;
	endfunction

	function automatic void next_field();
		if (field_no < INDEX_CAP)
			field_no = field_no + 8'd1;
	endfunction

	// advances the parser copy by one byte; returns 1 when the byte yields a word
	function automatic bit parse_byte(input in_item_t it, output out_item_t r);
		logic [7:0] b;
		logic [7:0] idx;
		bit last, is_q, is_d, hc, fd, pe, any;
		b    = it.data_byte;
		last = it.last_byte;
		idx  = field_no;
		hc   = 1'b0;
		fd   = 1'b0;
		pe   = 1'b0;
		any  = 1'b0;
		r    = '0;
		if (dropping) begin
			if (b == NEWLINE_BYTE || last) begin
				r = res(1'b0, 8'd0, 1'b0, 1'b1, 1'b0, field_no);
				line_reset();
				return 1'b1;
			end
			return 1'b0;
		end
		if (b == NEWLINE_BYTE) begin
			r = res(1'b0, 8'd0, 1'b1, 1'b1, 1'b0, field_no);
			line_reset();
			return 1'b1;
		end
		// quote wins when both registers hold the same byte
		is_q = (b == quo_byte);
		is_d = !is_q && (b == sep_byte);
		case (cur_mode)
			MODE_START: begin
				if (is_q) begin
					cur_mode = MODE_QUOTED;
				end else if (is_d) begin
					fd  = 1'b1;
					any = 1'b1;
					next_field();
				end else begin
					hc       = 1'b1;
					any      = 1'b1;
					cur_mode = MODE_PLAIN;
				end
			end
			MODE_QUOTED: begin
				if (is_q) begin
					cur_mode = MODE_AFTERQ;
				end else begin
					hc  = 1'b1;
					any = 1'b1;
				end
			end
			MODE_PLAIN: begin
				if (is_d) begin
					fd       = 1'b1;
					any      = 1'b1;
					cur_mode = MODE_START;
					next_field();
				end else begin
					hc  = 1'b1;
					any = 1'b1;
				end
			end
			default: begin
				if (is_q) begin
					hc       = 1'b1;
					any      = 1'b1;
					cur_mode = MODE_QUOTED;
				end else if (is_d) begin
					fd       = 1'b1;
					any      = 1'b1;
					cur_mode = MODE_START;
					next_field();
				end else begin
					pe  = 1'b1;
					any = 1'b1;
				end
			end
		endcase
		if (pe) begin
			r = res(1'b0, 8'd0, 1'b0, last, 1'b1, idx);
			if (last)
				line_reset();
			else
				dropping = 1'b1;
			return 1'b1;
		end
		if (last) begin
			// final field closes here, maybe an empty one
			r = res(hc, hc ? b : 8'd0, 1'b1, 1'b1, 1'b0, field_no);
			line_reset();
			return 1'b1;
		end
		if (!any)
			return 1'b0;
		r = res(hc, hc ? b : 8'd0, fd, 1'b0, 1'b0, idx);
		return 1'b1;
	endfunction

	task automatic offer(input in_item_t it);
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		sent_in_phase++;
	endtask

	task automatic feed(input in_item_t it);
		out_item_t r;
		offer(it);
		if (parse_byte(it, r))
			pending_results = {pending_results, r};
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(input logic [7:0] sep, input logic [7:0] quo);
		cfg_valid <= 1'b1;
		cfg_index <= REG_DELIMITER;
		cfg_data  <= sep;
		do @(posedge clk); while (!cfg_ready);
		sep_byte = sep;
		cfg_index <= REG_QUOTE_CHAR;
		cfg_data  <= quo;
		do @(posedge clk); while (!cfg_ready);
		quo_byte = quo;
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255));
		while (b == NEWLINE_BYTE || b == sep_byte || b == quo_byte);
		return b;
	endfunction

	// mostly well-formed lines with random content, some noise and stray bytes
	task automatic send_line();
		in_item_t line[$];
		int nf;
		if ($urandom_range(0, 99) < 15) begin
			repeat ($urandom_range(1, 12))
				line = {line, mk(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0)};
		end else begin
			nf = $urandom_range(1, 6);
			for (int f = 0; f < nf; f++) begin
				if (f > 0)
					line = {line, mk(sep_byte, 1'b0)};
				if ($urandom_range(0, 1)) begin
					line = {line, mk(quo_byte, 1'b0)};
					repeat ($urandom_range(0, 8)) begin
						case ($urandom_range(0, 5))
							0: begin
								line = {line, mk(quo_byte, 1'b0)};
								line = {line, mk(quo_byte, 1'b0)};
							end
							1: line = {line, mk(sep_byte, 1'b0)};
							default: line = {line, mk(plain_byte(), 1'b0)};
						endcase
					end
					line = {line, mk(quo_byte, 1'b0)};
					if ($urandom_range(0, 9) == 0)
						line = {line, mk(plain_byte(), 1'b0)};
				end else begin
					repeat ($urandom_range(0, 8))
						line = {line, mk(plain_byte(), 1'b0)};
				end
			end
			if ($urandom_range(0, 1) || line.size() == 0)
				line = {line, mk(NEWLINE_BYTE, 1'b0)};
			else
				line[line.size() - 1].last_byte = 1'b1;
		end
		foreach (line[i])
			feed(line[i]);
	endtask

	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected word %p", $realtime, out_data);
			end else begin
				oldest = pending_results.pop_front();
				if (out_data !== oldest) begin
					mismatch_count++;
					$display("%0t: mismatch expected %p actual %p", $realtime, oldest, out_data);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired", $realtime);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver side: random stall bursts, one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		stim_row_t dir_rows[$];
		reg_pair_t settings[$];
		out_item_t r;

		dir_rows = '{
			row("a",  1'b0, 1, 1'b1, 1'b0, res(1'b1, "a",  1'b0, 1'b0, 1'b0, 8'd0)),
			row(",",  1'b0, 1, 1'b1, 1'b0, res(1'b0, 8'd0, 1'b1, 1'b0, 1'b0, 8'd0)),
			row("\"", 1'b0, 1, 1'b1, 1'b1, '0),
			row(",",  1'b0, 1, 1'b1, 1'b0, res(1'b1, ",",  1'b0, 1'b0, 1'b0, 8'd1)),
			row("\"", 1'b0, 1, 1'b1, 1'b1, '0),
			row("\"", 1'b0, 1, 1'b1, 1'b0, res(1'b1, "\"", 1'b0, 1'b0, 1'b0, 8'd1)),
			row("\"", 1'b0, 1, 1'b1, 1'b1, '0),
			row("x",  1'b0, 1, 1'b1, 1'b0, res(1'b0, 8'd0, 1'b0, 1'b0, 1'b1, 8'd1)),
			row("y",  1'b0, 1, 1'b1, 1'b1, '0),
			row(NEWLINE_BYTE, 1'b0, 1, 1'b1, 1'b0, res(1'b0, 8'd0, 1'b0, 1'b1, 1'b0, 8'd1)),
			row(8'hFF, 1'b0, 1, 1'b1, 1'b0, res(1'b1, 8'hFF, 1'b0, 1'b0, 1'b0, 8'd0)),
			row("\"", 1'b0, 1, 1'b1, 1'b0, res(1'b1, "\"", 1'b0, 1'b0, 1'b0, 8'd0)),
			row(8'h00, 1'b1, 1, 1'b1, 1'b0, res(1'b1, 8'h00, 1'b1, 1'b1, 1'b0, 8'd0)),
			row(",",  1'b1, 1, 1'b1, 1'b0, res(1'b0, 8'd0, 1'b1, 1'b1, 1'b0, 8'd1)),
			row("\"", 1'b1, 1, 1'b1, 1'b0, res(1'b0, 8'd0, 1'b1, 1'b1, 1'b0, 8'd0)),
			row("\"", 1'b0, 1, 1'b1, 1'b1, '0),
			row("q",  1'b0, 1, 1'b1, 1'b0, res(1'b1, "q",  1'b0, 1'b0, 1'b0, 8'd0)),
			row("\"", 1'b0, 1, 1'b1, 1'b1, '0),
			row("z",  1'b1, 1, 1'b1, 1'b0, res(1'b0, 8'd0, 1'b0, 1'b1, 1'b1, 8'd0)),
			row(NEWLINE_BYTE, 1'b0, 1, 1'b1, 1'b0, res(1'b0, 8'd0, 1'b1, 1'b1, 1'b0, 8'd0)),
			// long run of empty fields drives the index into saturation
			row(",",  1'b0, 300, 1'b0, 1'b0, '0),
			row(NEWLINE_BYTE, 1'b0, 1, 1'b1, 1'b0, res(1'b0, 8'd0, 1'b1, 1'b1, 1'b0, 8'd255)),
			row("\"", 1'b0, 1, 1'b1, 1'b1, '0),
			row(NEWLINE_BYTE, 1'b0, 1, 1'b1, 1'b0, res(1'b0, 8'd0, 1'b1, 1'b1, 1'b0, 8'd0)),
			row("\"", 1'b0, 1, 1'b0, 1'b0, '0),
			row("\"", 1'b0, 1, 1'b0, 1'b0, '0),
			row("b",  1'b1, 1, 1'b0, 1'b0, '0)
		};

		settings = '{
			'{sep: 8'h00, quo: 8'hFF},
			'{sep: 8'hFF, quo: 8'h00},
			'{sep: 8'h3B, quo: 8'h27},
			'{sep: 8'h22, quo: 8'h22},
			'{sep: NEWLINE_BYTE, quo: 8'h22},
			'{sep: 8'h2C, quo: NEWLINE_BYTE},
			'{sep: DELIMITER_RST, quo: QUOTE_CHAR_RST}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct   = 15;
		stall_pct = 20;
		foreach (dir_rows[i]) begin
			for (int k = 0; k < dir_rows[i].reps; k++) begin
				if (dir_rows[i].typed) begin
					offer(dir_rows[i].item);
					void'(parse_byte(dir_rows[i].item, r));
					if (!dir_rows[i].silent)
						pending_results = {pending_results, dir_rows[i].want};
				end else begin
					feed(dir_rows[i].item);
				end
			end
		end

		foreach (settings[p]) begin
			drain();
			write_regs(settings[p].sep, settings[p].quo);
			gap_pct       = (p % 2) ? 0 : 20;
			stall_pct     = (p % 3 == 0) ? 0 : 25;
			calm          = (p == settings.size() - 1);
			sent_in_phase = 0;
			if (p == 1)
				hold_req = 1'b1;
			while (sent_in_phase < PHASE_ITEMS)
				send_line();
		end

		drain();
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
